### src/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force package
// Register indexes, reset values and shared types of the pair force pipeline.
// ----------------------------------------------------------------------------
package ljpf_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CELL_X  = 3'd0;
   localparam logic [2:0] CSR_CELL_Y  = 3'd1;
   localparam logic [2:0] CSR_CELL_Z  = 3'd2;
   localparam logic [2:0] CSR_CUTOFF  = 3'd3;

   // Register values after reset.
   localparam logic [30:0] RESET_CELL   = 31'd655360;
   localparam logic [30:0] RESET_CUTOFF = 31'd409600;

   // Saturation value of the 64-bit reciprocal arithmetic.
   localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

   // Magnitude width of the wrap dividend 2*d + cell.
   localparam int NUM_W = 34;

   // Per-pair data that rides alongside the reciprocal chain.
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       wneg;
      logic             in_range;
      logic             zero;
   } side_type;

endpackage

### src/lennard_jones_pair_force.sv
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair force with minimum-image wrapping
// Fixed-point force on the first atom of a pair, one pair per clock unless stalled.
// ----------------------------------------------------------------------------
// The block takes one atom pair per clock cycle while req_stall is low and
// returns its force, with no gaps between pairs. The depth comes from two
// dividers that resolve one bit per pipeline stage: the minimum-image wrap
// (34 stages) and the reciprocal of the squared distance (FRAC_BITS + 33
// stages), followed by three levels of 64-bit fractional multiplies built
// from 32 by 32 bit partial products. A result that waits on rsp_stall
// holds the pipeline only when its last stage carries a pair; bubbles keep
// draining, so pairs are still accepted behind a waiting result. Cell
// lengths and the squared cutoff must be written through the csr port only
// while no pair is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic               rsp_in_range,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int NW     = ljpf_pkg::NUM_W;
   localparam int ND     = FRAC_BITS + 33;
   localparam int SQ_W   = 64 - FRAC_BITS;
   localparam int R2_W   = SQ_W + 2;
   localparam int SIDE_N = ND + 14;
   localparam int NST    = ND + 56;

   // Configuration registers.
   logic [30:0] cell_ff [3];
   logic [30:0] cutoff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff[0] <= ljpf_pkg::RESET_CELL;
         cell_ff[1] <= ljpf_pkg::RESET_CELL;
         cell_ff[2] <= ljpf_pkg::RESET_CELL;
         cutoff_ff  <= ljpf_pkg::RESET_CUTOFF;
      end else if (csr_valid) begin
         case (csr_index)
            ljpf_pkg::CSR_CELL_X: cell_ff[0] <= csr_wdata[30:0];
            ljpf_pkg::CSR_CELL_Y: cell_ff[1] <= csr_wdata[30:0];
            ljpf_pkg::CSR_CELL_Z: cell_ff[2] <= csr_wdata[30:0];
            ljpf_pkg::CSR_CUTOFF: cutoff_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance: hold only when a finished pair meets a waiting result.
   logic [NST-1:0] v_ff;
   logic           rsp_valid_ff;
   logic           adv;
   logic           out_load;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign adv       = out_load || !v_ff[NST-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], req_valid};
      end
   end

   // Input stage: difference and wrap dividend per axis.
   logic signed [31:0] fst [3];
   logic signed [31:0] snd [3];
   assign fst[0] = req_first_x;
   assign fst[1] = req_first_y;
   assign fst[2] = req_first_z;
   assign snd[0] = req_second_x;
   assign snd[1] = req_second_y;
   assign snd[2] = req_second_z;

   logic signed [32:0] e_d_ff   [3];
   logic [NW-1:0]      e_mag_ff [3];
   logic               e_neg_ff [3];

   logic [31:0]        dv_rem_ff [3][NW];
   logic [NW-1:0]      dv_mag_ff [3][NW];
   logic               dv_neg_ff [3][NW];
   logic signed [32:0] dv_d_ff   [3][NW];

   logic signed [32:0] w_ff    [3];
   logic [31:0]        mag_ff  [3];
   logic               wneg_ff [3];
   logic [SQ_W-1:0]    sq_ff   [3];
   logic [31:0]        mq_ff   [3];
   logic               nq_ff   [3];
   logic [31:0]        mr_ff   [3];
   logic               nr_ff   [3];

   genvar a, j;
   generate
      for (a = 0; a < 3; a++) begin : g_axis
         logic signed [32:0] d_in;
         logic signed [34:0] num_in;
         logic [34:0]        abs_in;
         logic [31:0]        den;

         assign den    = {cell_ff[a], 1'b0};
         assign d_in   = {fst[a][31], fst[a]} - {snd[a][31], snd[a]};
         assign num_in = {d_in[32], d_in, 1'b0} + {4'b0000, cell_ff[a]};
         assign abs_in = num_in[34] ? (35'd0 - num_in) : num_in;

         always_ff @(posedge clock) begin
            if (adv) begin
               e_d_ff[a]   <= d_in;
               e_mag_ff[a] <= abs_in[NW-1:0];
               e_neg_ff[a] <= num_in[34];
            end
         end

         // Wrap divider: |2d + cell| mod 2*cell, one dividend bit per stage.
         for (j = 0; j < NW; j++) begin : g_div
            logic [31:0]        rem_prev;
            logic [NW-1:0]      mag_prev;
            logic               neg_prev;
            logic signed [32:0] d_prev;
            logic [32:0]        t;
            logic [32:0]        t_sub;
            logic [31:0]        rem_in;

            if (j == 0) begin : g_first
               assign rem_prev = '0;
               assign mag_prev = e_mag_ff[a];
               assign neg_prev = e_neg_ff[a];
               assign d_prev   = e_d_ff[a];
            end else begin : g_next
               assign rem_prev = dv_rem_ff[a][j-1];
               assign mag_prev = dv_mag_ff[a][j-1];
               assign neg_prev = dv_neg_ff[a][j-1];
               assign d_prev   = dv_d_ff[a][j-1];
            end

            assign t      = {rem_prev, mag_prev[NW-1-j]};
            assign t_sub  = t - {1'b0, den};
            assign rem_in = (t >= {1'b0, den}) ? t_sub[31:0] : t[31:0];

            always_ff @(posedge clock) begin
               if (adv) begin
                  dv_rem_ff[a][j] <= rem_in;
                  dv_mag_ff[a][j] <= mag_prev;
                  dv_neg_ff[a][j] <= neg_prev;
                  dv_d_ff[a][j]   <= d_prev;
               end
            end
         end

         // Floor remainder, then the wrapped difference (rem - cell) / 2, or d for a zero cell.
         logic [31:0]        rem_last;
         logic [31:0]        rem_f;
         logic signed [33:0] half2;
         logic signed [32:0] w_in;
         logic [32:0]        wabs;

         assign rem_last = dv_rem_ff[a][NW-1];
         assign rem_f    = (dv_neg_ff[a][NW-1] && (rem_last != 32'd0)) ?
                           (den - rem_last) : rem_last;
         assign half2    = $signed({2'b00, rem_f}) - $signed({3'b000, cell_ff[a]});
         assign w_in     = (cell_ff[a] == 31'd0) ? dv_d_ff[a][NW-1] : half2[33:1];
         assign wabs     = w_ff[a][32] ? (33'd0 - w_ff[a]) : w_ff[a];

         logic [63:0] sq_full;
         assign sq_full = mag_ff[a] * mag_ff[a];

         always_ff @(posedge clock) begin
            if (adv) begin
               w_ff[a]    <= w_in;
               mag_ff[a]  <= wabs[31:0];
               wneg_ff[a] <= w_ff[a][32];
               sq_ff[a]   <= sq_full[63:FRAC_BITS];
               mq_ff[a]   <= mag_ff[a];
               nq_ff[a]   <= wneg_ff[a];
               mr_ff[a]   <= mq_ff[a];
               nr_ff[a]   <= nq_ff[a];
            end
         end
      end
   endgenerate

   // Squared distance and the cutoff compare.
   logic [R2_W-1:0]    r2_ff;
   logic [R2_W-1:0]    r2_in;
   logic [30:0]        r2c_ff;
   ljpf_pkg::side_type side_c_ff;
   ljpf_pkg::side_type side_in;

   assign r2_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};

   always_comb begin
      side_in.mag[0]  = mr_ff[0];
      side_in.mag[1]  = mr_ff[1];
      side_in.mag[2]  = mr_ff[2];
      side_in.wneg[0] = nr_ff[0];
      side_in.wneg[1] = nr_ff[1];
      side_in.wneg[2] = nr_ff[2];
      side_in.in_range = (r2_ff <= {{(R2_W-31){1'b0}}, cutoff_ff});
      side_in.zero     = (r2_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_ff     <= r2_in;
         r2c_ff    <= r2_ff[30:0];
         side_c_ff <= side_in;
      end
   end

   // Reciprocal divider: 2^(FRAC_BITS+32) / r2, one quotient bit per stage.
   logic [30:0]   q2_rem_ff [ND];
   logic [30:0]   q2_div_ff [ND];
   logic [ND-1:0] q2_q_ff   [ND];

   generate
      for (j = 0; j < ND; j++) begin : g_recip
         logic [30:0]   rem_prev;
         logic [30:0]   div_prev;
         logic [ND-1:0] q_prev;
         logic [31:0]   t;
         logic [31:0]   t_sub;
         logic          qbit;

         if (j == 0) begin : g_first
            assign rem_prev = '0;
            assign div_prev = r2c_ff;
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = q2_rem_ff[j-1];
            assign div_prev = q2_div_ff[j-1];
            assign q_prev   = q2_q_ff[j-1];
         end

         assign t     = {rem_prev, 1'(j == 0)};
         assign t_sub = t - {1'b0, div_prev};
         assign qbit  = (t >= {1'b0, div_prev});

         always_ff @(posedge clock) begin
            if (adv) begin
               q2_rem_ff[j] <= qbit ? t_sub[30:0] : t[30:0];
               q2_div_ff[j] <= div_prev;
               q2_q_ff[j]   <= {q_prev[ND-2:0], qbit};
            end
         end
      end
   endgenerate

   // Fractional multiplies floor(a*b / 2^32), saturated, four stages each.
   logic [63:0] i2;
   logic [63:0] mu_a      [4];
   logic [63:0] mu_b      [4];
   logic [63:0] m3_r_ff   [4];
   logic [63:0] i2d_ff    [4];
   logic [63:0] i8d_ff    [4];

   assign i2 = {{(64-ND){1'b0}}, q2_q_ff[ND-1]};

   // Slots: i4 = i2*i2, i6 = i4*i2, i8 = i4*i4, i14 = i8*i6.
   assign mu_a[0] = i2;
   assign mu_b[0] = i2;
   assign mu_a[1] = m3_r_ff[0];
   assign mu_b[1] = i2d_ff[3];
   assign mu_a[2] = m3_r_ff[0];
   assign mu_b[2] = m3_r_ff[0];
   assign mu_a[3] = m3_r_ff[2];
   assign mu_b[3] = m3_r_ff[1];

   always_ff @(posedge clock) begin
      if (adv) begin
         i2d_ff[0] <= i2;
         i8d_ff[0] <= m3_r_ff[2];
         for (int k = 1; k < 4; k++) begin
            i2d_ff[k] <= i2d_ff[k-1];
            i8d_ff[k] <= i8d_ff[k-1];
         end
      end
   end

   genvar s;
   generate
      for (s = 0; s < 4; s++) begin : g_mul
         logic [63:0] hh0_ff, hl0_ff, lh0_ff, ll0_ff;
         logic [63:0] hh1_ff;
         logic [64:0] mid1_ff;
         logic [31:0] lo1_ff;
         logic [63:0] hh2_ff;
         logic [65:0] t2_ff;
         logic [96:0] total;

         assign total = {1'b0, hh2_ff, 32'h0} + {31'b0, t2_ff};

         always_ff @(posedge clock) begin
            if (adv) begin
               hh0_ff     <= mu_a[s][63:32] * mu_b[s][63:32];
               hl0_ff     <= mu_a[s][63:32] * mu_b[s][31:0];
               lh0_ff     <= mu_a[s][31:0]  * mu_b[s][63:32];
               ll0_ff     <= mu_a[s][31:0]  * mu_b[s][31:0];
               hh1_ff     <= hh0_ff;
               mid1_ff    <= {1'b0, hl0_ff} + {1'b0, lh0_ff};
               lo1_ff     <= ll0_ff[63:32];
               hh2_ff     <= hh1_ff;
               t2_ff      <= {1'b0, mid1_ff} + {34'b0, lo1_ff};
               m3_r_ff[s] <= (total[96:64] != '0) ? ljpf_pkg::SAT64 : total[63:0];
            end
         end
      end
   endgenerate

   // Coefficient 24 * (2*i14 - i8), magnitude and sign.
   logic [63:0] a2;
   logic [63:0] diff_ff;
   logic        cneg_ff;
   logic [68:0] p24;
   logic [63:0] coef_ff;
   logic        cnegb_ff;

   assign a2  = m3_r_ff[3][63] ? ljpf_pkg::SAT64 : {m3_r_ff[3][62:0], 1'b0};
   assign p24 = {1'b0, diff_ff, 4'b0000} + {2'b00, diff_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (adv) begin
         if (a2 >= i8d_ff[3]) begin
            diff_ff <= a2 - i8d_ff[3];
            cneg_ff <= 1'b0;
         end else begin
            diff_ff <= i8d_ff[3] - a2;
            cneg_ff <= 1'b1;
         end
         coef_ff  <= (p24[68:64] != '0) ? ljpf_pkg::SAT64 : p24[63:0];
         cnegb_ff <= cneg_ff;
      end
   end

   // Side data delay matching the reciprocal chain.
   ljpf_pkg::side_type sd_ff [SIDE_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= side_c_ff;
         for (int k = 1; k < SIDE_N; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // Component products |w| * coef / 2^32, then clip to 32 bits and zero out-of-range pairs.
   ljpf_pkg::side_type sb;
   logic [63:0]        coef_e;
   logic               neg_e;
   logic [63:0]        ph_ff [3];
   logic [63:0]        pl_ff [3];
   logic               pneg_ff [3];
   logic               p_inr_ff, p_zero_ff;
   logic [64:0]        sm_ff [3];
   logic               sneg_ff [3];
   logic               s_inr_ff, s_zero_ff;

   assign sb     = sd_ff[SIDE_N-1];
   assign coef_e = sb.zero ? ljpf_pkg::SAT64 : coef_ff;
   assign neg_e  = !sb.zero && cnegb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            ph_ff[k]   <= sb.mag[k] * coef_e[63:32];
            pl_ff[k]   <= sb.mag[k] * coef_e[31:0];
            pneg_ff[k] <= sb.wneg[k] ^ neg_e;
            sm_ff[k]   <= {1'b0, ph_ff[k]} + {33'b0, pl_ff[k][63:32]};
            sneg_ff[k] <= pneg_ff[k];
         end
         p_inr_ff  <= sb.in_range;
         p_zero_ff <= sb.zero;
         s_inr_ff  <= p_inr_ff;
         s_zero_ff <= p_zero_ff;
      end
   end

   logic signed [31:0] f_in [3];
   logic               over [3];
   logic               sat_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (sneg_ff[k]) begin
            over[k] = (sm_ff[k] > 65'h0_8000_0000);
            f_in[k] = over[k] ? 32'sh8000_0000 : (32'sd0 - sm_ff[k][31:0]);
         end else begin
            over[k] = (sm_ff[k] > 65'h0_7FFF_FFFF);
            f_in[k] = over[k] ? 32'sh7FFF_FFFF : sm_ff[k][31:0];
         end
         if (!s_inr_ff) begin
            f_in[k] = '0;
         end
      end
      sat_in = s_inr_ff && (s_zero_ff || over[0] || over[1] || over[2]);
   end

   // Output register: loads whenever the result slot is free.
   logic signed [31:0] rsp_force_ff [3];
   logic               rsp_in_range_ff;
   logic               rsp_saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= v_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_force_ff[0]  <= f_in[0];
         rsp_force_ff[1]  <= f_in[1];
         rsp_force_ff[2]  <= f_in[2];
         rsp_in_range_ff  <= s_inr_ff;
         rsp_saturated_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_force_x   = rsp_force_ff[0];
   assign rsp_force_y   = rsp_force_ff[1];
   assign rsp_force_z   = rsp_force_ff[2];
   assign rsp_in_range  = rsp_in_range_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // An accepted pair occupies the first pipeline stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted pair missing from first stage");

   // A finished pair is never pushed over a waiting result.
   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NST-1] && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("pipeline advanced over a waiting result");

   // Out-of-range pairs carry zero force and no saturation.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_in_range_ff) |->
      (rsp_force_ff[0] == 32'sd0 && rsp_force_ff[1] == 32'sd0 &&
       rsp_force_ff[2] == 32'sd0 && !rsp_saturated_ff))
      else $error("out-of-range result with nonzero force");

endmodule

### bench/lennard_jones_pair_force_test.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force testbench
// Drives atom pairs and register writes into the pair force pipeline and
// checks every result against a bit-exact fixed-point force predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lennard_jones_pair_force_test;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 90;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF;
   localparam logic [63:0] NEG_MAX = 64'h8000_0000;
   // Register index past the end of the register list.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
      logic               in_range;
      logic               saturated;
   } force_type;

   typedef struct {
      logic signed [31:0] pos [6];
      logic               has_check;
      force_type          check;
   } pair_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_first_x, req_first_y, req_first_z;
   logic signed [31:0] req_second_x, req_second_y, req_second_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_in_range, rsp_saturated;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   // Predictor copy of the registers.
   logic [30:0] cell_len [3];
   logic [30:0] cutoff_sq;

   force_type expected_forces [$];
   int error_count;
   int pair_count;
   int force_count;

   lennard_jones_pair_force i_dut (.*);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #40ms;
      $display("lennard_jones_pair_force_test failed");
      $finish;
   end

   // Truncated fractional product, saturated to all ones.
   function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:96] != 0) return ljpf_pkg::SAT64;
      return p[95:32];
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? ljpf_pkg::SAT64 : s[63:0];
   endfunction

   // Minimum-image wrap of one axis difference.
   function automatic longint wrap_image(longint d, logic [30:0] c);
      longint num, den, k;
      if (c == 0) return d;
      num = 2 * d + longint'(c);
      den = 2 * longint'(c);
      k = num / den;
      if ((num % den) != 0 && num < 0) k = k - 1;
      return d - k * longint'(c);
   endfunction

   // Expected force on the first atom of a pair.
   function automatic force_type pair_force(logic signed [31:0] pos [6]);
      force_type f;
      longint w [3];
      logic [63:0] mag [3];
      logic [63:0] r2, coef, i2, i4, i6, i8, i14, a, diff, m;
      logic coef_neg, sat, neg;
      logic signed [31:0] comp [3];
      r2 = 0;
      coef_neg = 1'b0;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         w[i] = wrap_image(longint'(pos[i]) - longint'(pos[i + 3]), cell_len[i]);
         mag[i] = (w[i] < 0) ? 64'(-w[i]) : 64'(w[i]);
         r2 = r2 + ((mag[i] * mag[i]) >> FRAC);
      end
      f = '0;
      if (r2 > {33'd0, cutoff_sq}) return f;
      if (r2 == 0) begin
         sat = 1'b1;
         coef = ljpf_pkg::SAT64;
      end else begin
         i2 = (64'd1 << (FRAC + 32)) / r2;
         i4 = mul_frac(i2, i2);
         i6 = mul_frac(i4, i2);
         i8 = mul_frac(i4, i4);
         i14 = mul_frac(i8, i6);
         a = add_sat(i14, i14);
         if (a >= i8) diff = a - i8;
         else begin
            diff = i8 - a;
            coef_neg = 1'b1;
         end
         coef = 0;
         for (int j = 0; j < 24; j++) coef = add_sat(coef, diff);
      end
      for (int i = 0; i < 3; i++) begin
         m = (w[i] == 0) ? 64'd0 : mul_frac(mag[i], coef);
         neg = (w[i] < 0) != coef_neg;
         if (neg) begin
            if (m > NEG_MAX) begin
               m = NEG_MAX;
               sat = 1'b1;
            end
            comp[i] = -m[31:0];
         end else begin
            if (m > POS_MAX) begin
               m = POS_MAX;
               sat = 1'b1;
            end
            comp[i] = m[31:0];
         end
      end
      f.fx = comp[0];
      f.fy = comp[1];
      f.fz = comp[2];
      f.in_range = 1'b1;
      f.saturated = sat;
      return f;
   endfunction

   // Send one pair; the expectation is queued at the accepting edge.
   // Valid stays high after a transfer so that pairs can follow back to back.
   task automatic send_pair(logic signed [31:0] pos [6], logic has_check,
                            force_type check);
      force_type f;
      int idle;
      idle = $urandom_range(0, 10);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      f = pair_force(pos);
      if (has_check && f != check) begin
         $display("%0t: table entry disagrees, expected %h predicted %h",
                  $time, check, f);
         error_count++;
      end
      req_valid <= 1'b1;
      req_first_x <= pos[0];
      req_first_y <= pos[1];
      req_first_z <= pos[2];
      req_second_x <= pos[3];
      req_second_y <= pos[4];
      req_second_z <= pos[5];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_forces = {expected_forces, f};
      pair_count++;
   endtask

   // Register write, only while the pipeline is empty.
   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == ljpf_pkg::CSR_CUTOFF) cutoff_sq = value[30:0];
      else if (index <= ljpf_pkg::CSR_CELL_Z) cell_len[index] = value[30:0];
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Random pair: mostly near pairs, some coincident, some anywhere.
   task automatic random_pair();
      logic signed [31:0] pos [6];
      force_type none;
      none = '0;
      for (int i = 0; i < 3; i++) begin
         pos[i] = $urandom;
         case ($urandom_range(0, 9))
            0, 1: pos[i + 3] = $urandom;
            2: pos[i + 3] = pos[i];
            default: pos[i + 3] = pos[i] + $signed($urandom_range(0, 360000)) - 180000;
         endcase
      end
      send_pair(pos, 1'b0, none);
   endtask

   // Result side: a random wait after each transfer, and a check against the
   // oldest expectation.
   initial begin
      force_type got, want;
      int hold;
      rsp_stall = 1'b1;
      hold = $urandom_range(0, 10);
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_force_x, rsp_force_y, rsp_force_z, rsp_in_range, rsp_saturated};
            if (expected_forces.size() == 0) begin
               $display("%0t: expected no result, actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_forces.pop_front();
               force_count++;
               if (got.fx != want.fx)
                  $display("%0t: force_x expected %0d actual %0d", $time, want.fx, got.fx);
               if (got.fy != want.fy)
                  $display("%0t: force_y expected %0d actual %0d", $time, want.fy, got.fy);
               if (got.fz != want.fz)
                  $display("%0t: force_z expected %0d actual %0d", $time, want.fz, got.fz);
               if (got.in_range != want.in_range)
                  $display("%0t: in_range expected %0b actual %0b", $time,
                           want.in_range, got.in_range);
               if (got.saturated != want.saturated)
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.saturated, got.saturated);
               if (got != want) error_count++;
            end
            hold = $urandom_range(0, 10);
         end else if (hold != 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   // Stimulus.
   initial begin
      pair_row_type rows [$];
      pair_row_type row;
      force_type none;
      logic [31:0] cell_choice [4];
      none = '0;
      error_count = 0;
      pair_count = 0;
      force_count = 0;
      cell_len = '{ljpf_pkg::RESET_CELL, ljpf_pkg::RESET_CELL, ljpf_pkg::RESET_CELL};
      cutoff_sq = ljpf_pkg::RESET_CUTOFF;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_first_x, req_first_y, req_first_z} = '0;
      {req_second_x, req_second_y, req_second_z} = '0;
      csr_valid = 1'b0;
      csr_index = ljpf_pkg::CSR_CELL_X;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset settings; rows with has_check clear are computed only.
      row.has_check = 1'b0;
      row.check = none;
      // Coincident atoms: zero distance, all components zero, saturated.
      row.pos = '{0, 0, 0, 0, 0, 0};
      row.has_check = 1'b1;
      row.check = '{0, 0, 0, 1'b1, 1'b1};
      rows = {rows, row};
      // Coincident after one full cell wrap.
      row.pos = '{655360, 0, 0, 0, 0, 0};
      rows = {rows, row};
      // Separated by half a cell: beyond the cutoff.
      row.pos = '{327680, 0, 0, 0, 0, 0};
      row.check = '0;
      rows = {rows, row};
      // Extremes of the positions.
      row.pos = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
      row.has_check = 1'b0;
      rows = {rows, row};
      row.pos = '{32'sh80000000, 32'sh7FFFFFFF, -1, 32'sh7FFFFFFF, 32'sh80000000, 0};
      rows = {rows, row};
      // Repulsive, attractive, and near the minimum and cutoff.
      row.pos = '{65536, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.pos = '{0, 0, 0, 40000, 0, 0};
      rows = {rows, row};
      row.pos = '{73562, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.pos = '{0, 163840, 0, 0, 0, 0};
      rows = {rows, row};
      row.pos = '{0, 0, 163841, 0, 0, 0};
      rows = {rows, row};
      row.pos = '{1, 0, 0, 0, 0, 0};
      rows = {rows, row};
      row.pos = '{100, -200, 300, -50, 60, 70};
      rows = {rows, row};
      row.pos = '{80000, 80000, 80000, 0, 0, 0};
      rows = {rows, row};
      foreach (rows[i]) send_pair(rows[i].pos, rows[i].has_check, rows[i].check);
      drain_pipeline();

      // Zero cells disable wrapping; extreme cutoff.
      write_reg(ljpf_pkg::CSR_CELL_X, 32'd0);
      write_reg(ljpf_pkg::CSR_CELL_Y, 32'd0);
      write_reg(ljpf_pkg::CSR_CELL_Z, 32'd0);
      write_reg(ljpf_pkg::CSR_CUTOFF, 32'h7FFFFFFF);
      row.pos = '{32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0, 0};
      send_pair(row.pos, 1'b0, none);
      row.pos = '{0, 0, 0, 0, 0, 0};
      send_pair(row.pos, 1'b1, '{0, 0, 0, 1'b1, 1'b1});
      row.pos = '{655360, 0, 0, 0, 0, 0};
      send_pair(row.pos, 1'b0, none);
      drain_pipeline();
      // Index past the register list is ignored.
      write_reg(CSR_UNUSED, 32'h0000_1234);
      write_reg(ljpf_pkg::CSR_CUTOFF, 32'd0);
      row.pos = '{1, 0, 0, 0, 0, 0};
      send_pair(row.pos, 1'b0, none);
      row.pos = '{300, 0, 0, 0, 0, 0};
      send_pair(row.pos, 1'b1, '0);
      drain_pipeline();

      // Random phases across several register settings.
      for (int phase = 0; phase < 6; phase++) begin
         cell_choice = '{32'h7FFFFFFF, 32'd1, 32'd655360, 32'd300000};
         for (int i = 0; i < 3; i++)
            write_reg(ljpf_pkg::CSR_CELL_X + 3'(i), phase == 0 ? 32'd655360 :
                      (phase == 1 ? cell_choice[i] : 32'($urandom_range(1, 2000000))));
         write_reg(ljpf_pkg::CSR_CUTOFF, phase == 2 ? 32'h7FFFFFFF :
                   (phase == 3 ? 32'd0 : $urandom_range(1000, 1200000)));
         for (int n = 0; n < 88; n++) random_pair();
         drain_pipeline();
      end
      write_reg(ljpf_pkg::CSR_CELL_X, 32'hFFFF_FFFF);
      write_reg(ljpf_pkg::CSR_CELL_Y, 32'd65536);
      write_reg(ljpf_pkg::CSR_CELL_Z, 32'd1);
      write_reg(ljpf_pkg::CSR_CUTOFF, 32'hFFFF_FFFF);
      for (int n = 0; n < 20; n++) random_pair();

      drain_pipeline();
      if (expected_forces.size() != 0) error_count++;
      $display("Covered %0d pairs and %0d checked forces over several cell and cutoff",
               pair_count, force_count);
      $display("settings, including zero distance, zero cells and clipped forces.");
      if (error_count == 0) $display("lennard_jones_pair_force_test passed");
      else $display("lennard_jones_pair_force_test failed");
      $finish;
   end

endmodule

### lennard_jones_pair_force.f
src/ljpf_pkg.sv
src/lennard_jones_pair_force.sv
bench/lennard_jones_pair_force_test.sv
